>>> design/uol_pkg.sv
// Shared types and codes for the unique ordered list.
`timescale 1ns / 1ps

package uol_pkg;

    // Command operation codes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_BADOP = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_BUSY = 1'b1
    } t_state;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic ins;   // shift toward the tail, head takes the new word
        logic del;   // cells at and past the hit take their right neighbor
    } t_cell_ctl;

    localparam int unsigned ValueW = 32;
    localparam int unsigned CountW = 5;

endpackage

>>> design/uol_cell.sv
// One list slot: holds a value and an occupied flag, compares and shifts.
`timescale 1ns / 1ps

module uol_cell
    import uol_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctl                i_ctl,
    input  logic signed [ValueW-1:0] i_key,
    input  logic signed [ValueW-1:0] i_left_value,
    input  logic                     i_left_valid,
    input  logic signed [ValueW-1:0] i_right_value,
    input  logic                     i_right_valid,
    input  logic                     i_hit,
    output logic signed [ValueW-1:0] o_value,
    output logic                     o_valid,
    output logic                     o_hit
);

    logic signed [ValueW-1:0] r_value;
    logic                     r_valid;
    logic                     w_match;

    // Match against the command key; hit carries "matched here or earlier"
    assign w_match = r_valid && (r_value == i_key);
    assign o_hit   = i_hit || w_match;

    // Slot value: no reset, only read while occupied
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            r_value <= i_left_value;
        end else if (i_ctl.del && o_hit) begin
            r_value <= i_right_value;
        end
    end

    // Occupied flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.ins) begin
            r_valid <= i_left_valid;
        end else if (i_ctl.del && o_hit) begin
            r_valid <= i_right_valid;
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

>>> design/unique_ordered_list.sv
// Top level of the unique ordered list: command sequencer and row of slot cells.
`timescale 1ns / 1ps

// Holds up to CAPACITY distinct signed 32-bit values, newest at the head.
// Each command (insert if absent, delete first match, search) returns one
// word with a status and the entry count after the command. The accept
// edge latches a command; on the update edge, held off while an earlier
// result waits at a stalled output, every cell compares its value with
// the key in parallel, an insert shifts the whole row by one slot and a
// delete shifts the cells at and past the hit. The input stalls until that
// update. A finished result waits in the output register while the next
// command is accepted. entry_count carries the low five bits of the count.

module unique_ordered_list
    import uol_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_op,
    input  logic signed [ValueW-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_status,
    output logic [CountW-1:0]        o_entry_count
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    t_state                   r_state, n_state;
    t_op                      r_cmd_op;
    logic signed [ValueW-1:0] r_cmd_value;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_out_valid;
    t_status                  r_out_status, n_status;
    t_cell_ctl                w_ctl;
    logic                     w_accept;
    logic                     w_update;
    logic                     w_full;
    logic                     w_any_hit;

    logic signed [ValueW-1:0] c_val [CAPACITY+2];
    logic                     c_vld [CAPACITY+2];
    logic                     c_hit [CAPACITY+1];
    logic [CAPACITY-1:0]      w_occ;

    // Command register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd_op    <= t_op'(i_op);
            r_cmd_value <= i_value;
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_BUSY;
            S_BUSY: if (w_update) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_stall = 1'b0;
        w_update   = 1'b0;
        unique case (r_state)
            S_IDLE: o_in_stall = 1'b0;
            S_BUSY: begin
                o_in_stall = 1'b1;
                w_update   = !r_out_valid || !i_out_stall;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_full   = (r_count == CW'(CAPACITY));

    // Decide status, row control and new count
    always_comb begin
        n_status  = ST_BADOP;
        n_count   = r_count;
        w_ctl.ins = 1'b0;
        w_ctl.del = 1'b0;
        unique case (r_cmd_op)
            OP_INSERT: begin
                if (w_any_hit) begin
                    n_status = ST_MISS;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status  = ST_OK;
                    n_count   = r_count + CW'(1);
                    w_ctl.ins = w_update;
                end
            end
            OP_DELETE: begin
                if (w_any_hit) begin
                    n_status  = ST_OK;
                    n_count   = r_count - CW'(1);
                    w_ctl.del = w_update;
                end else begin
                    n_status = ST_MISS;
                end
            end
            OP_SEARCH: n_status = w_any_hit ? ST_OK : ST_MISS;
            default:   n_status = ST_BADOP;
        endcase
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_update) begin
            r_count <= n_count;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_update) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_out_status  <= n_status;
            o_entry_count <= CountW'(n_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;

    // Chain ends: head sees the key as its left neighbor, tail sees empty
    assign c_val[0]          = r_cmd_value;
    assign c_vld[0]          = 1'b1;
    assign c_val[CAPACITY+1] = '0;
    assign c_vld[CAPACITY+1] = 1'b0;
    assign c_hit[0]          = 1'b0;
    assign w_any_hit         = c_hit[CAPACITY];

    // Row of slot cells, slot 0 is the head
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        uol_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_key        (r_cmd_value),
            .i_left_value (c_val[g]),
            .i_left_valid (c_vld[g]),
            .i_right_value(c_val[g+2]),
            .i_right_valid(c_vld[g+2]),
            .i_hit        (c_hit[g]),
            .o_value      (c_val[g+1]),
            .o_valid      (c_vld[g+1]),
            .o_hit        (c_hit[g+1])
        );
        assign w_occ[g] = c_vld[g+1];
    end

    // Count never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // Occupied cells always match the count
    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_occ) == int'(r_count))
        else $error("occupied cells disagree with count");

    // Count moves only on an update edge
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_update |=> $stable(r_count))
        else $error("count changed outside an update");

    // A result appears only after a busy cycle
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_BUSY))
        else $error("result without a command in work");

endmodule

>>> verif/tb.sv
// Self-checking testbench for the unique ordered list.
`timescale 1ns / 1ps

module tb;
    import uol_pkg::*;

    localparam int unsigned CAP = 16;
    localparam int unsigned NUM_RANDOM = 1500;
    localparam int unsigned PHASE_LEN = 100;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Word picked by a phase's operation mix
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } t_mix;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_op = OP_INSERT;
    logic [ValueW-1:0]  i_value = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_status;
    logic [CountW-1:0]  o_entry_count;

    // Idle enables for the two sides, switched per phase
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int unsigned cycles = 0;

    // Tracks the list contents and the results each command should return
    class list_checker;
        logic [ValueW-1:0] held[$];
        logic [1:0]        want_status[$];
        logic [CountW-1:0] want_count[$];
        int                fails = 0;

        function int slot_of(logic [ValueW-1:0] v);
            foreach (held[i])
                if (held[i] == v)
                    return i;
            return -1;
        endfunction

        function int pending();
            return want_status.size();
        endfunction

        function void note_command(logic [1:0] op, logic [ValueW-1:0] v);
            int slot;
            logic [1:0] st;
            slot = slot_of(v);
            case (op)
                OP_INSERT: begin
                    if (slot >= 0)
                        st = ST_MISS;
                    else if (held.size() >= CAP)
                        st = ST_FULL;
                    else begin
                        held.push_front(v);
                        st = ST_OK;
                    end
                end
                OP_DELETE: begin
                    if (slot >= 0) begin
                        held.delete(slot);
                        st = ST_OK;
                    end else
                        st = ST_MISS;
                end
                OP_SEARCH: st = (slot >= 0) ? ST_OK : ST_MISS;
                default:   st = ST_BADOP;
            endcase
            want_status.push_back(st);
            want_count.push_back(CountW'(held.size()));
        endfunction

        function void check_result(logic [1:0] status, logic [CountW-1:0] count);
            logic [1:0] st;
            logic [CountW-1:0] cnt;
            if (want_status.size() == 0) begin
                $error("result with nothing expected: status %0d entry_count %0d",
                       status, count);
                fails++;
                return;
            end
            st = want_status.pop_front();
            cnt = want_count.pop_front();
            if (status !== st) begin
                $error("status: expected %0d, got %0d", st, status);
                fails++;
            end
            if (count !== cnt) begin
                $error("entry_count: expected %0d, got %0d", cnt, count);
                fails++;
            end
        endfunction
    endclass

    list_checker sb = new();
    logic [ValueW-1:0] pool[24];

    unique_ordered_list #(
        .CAPACITY(CAP)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("unique_ordered_list test failed");
            $finish;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_status, o_entry_count);
    end

    // Result side: while rx_idle is set, stall a random number of cycles before each word
    initial begin
        int unsigned n;
        @(posedge i_clk);
        forever begin
            n = rx_idle ? $urandom_range(0, 9) : 0;
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(i_rst_n && o_out_valid));
        end
    end

    // Drive one command word and hold it until the block takes it
    task automatic send_cmd(logic [1:0] op, logic [ValueW-1:0] v);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_value <= v;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_command(op, v);
    endtask

    // Fresh value pool: extremes plus random patterns, larger than the capacity
    task automatic refill_pool();
        pool[0] = 32'h8000_0000;
        pool[1] = 32'h7FFF_FFFF;
        pool[2] = 32'h0000_0000;
        pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < 24; i++)
            pool[i] = $urandom;
    endtask

    task automatic random_cmd(t_mix mix);
        int unsigned r;
        int unsigned ins_pct;
        int unsigned del_pct;
        logic [1:0] op;
        logic [ValueW-1:0] v;
        case (mix)
            MIX_FILL:  begin ins_pct = 70; del_pct = 12; end
            MIX_DRAIN: begin ins_pct = 15; del_pct = 65; end
            default:   begin ins_pct = 40; del_pct = 35; end
        endcase
        r = $urandom_range(0, 99);
        if (r < 3)
            op = OP_UNUSED;
        else if (r < 3 + ins_pct)
            op = OP_INSERT;
        else if (r < 3 + ins_pct + del_pct)
            op = OP_DELETE;
        else
            op = OP_SEARCH;
        // mostly pool values so hits and duplicates are common
        if ($urandom_range(0, 19) == 0)
            v = $urandom;
        else
            v = pool[$urandom_range(0, 23)];
        send_cmd(op, v);
    endtask

    initial begin
        t_mix mix;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty list, unknown op, extremes, duplicates, miss, full
        send_cmd(OP_SEARCH, 32'h0000_0001);
        send_cmd(OP_DELETE, 32'h0000_0001);
        send_cmd(OP_UNUSED, 32'h0000_0000);
        send_cmd(OP_INSERT, 32'h8000_0000);
        send_cmd(OP_INSERT, 32'h7FFF_FFFF);
        send_cmd(OP_INSERT, 32'h0000_0000);
        send_cmd(OP_INSERT, 32'hFFFF_FFFF);
        send_cmd(OP_INSERT, 32'h7FFF_FFFF);
        send_cmd(OP_SEARCH, 32'h8000_0000);
        send_cmd(OP_SEARCH, 32'h0000_0005);
        send_cmd(OP_DELETE, 32'h0000_0000);
        send_cmd(OP_DELETE, 32'h0000_0000);
        for (int k = 0; k < CAP - 3; k++)
            send_cmd(OP_INSERT, 32'h55AA_0000 + k);
        send_cmd(OP_INSERT, 32'h1234_5678);
        send_cmd(OP_INSERT, 32'h7FFF_FFFF);
        send_cmd(OP_UNUSED, 32'hFFFF_FFFF);

        // Random phases with varying operation mix and idle behavior
        for (int p = 0; p < NUM_RANDOM / PHASE_LEN; p++) begin
            refill_pool();
            mix = t_mix'($urandom_range(0, 2));
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_LEN; i++)
                random_cmd(mix);
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fails == 0)
            $display("unique_ordered_list test passed");
        else
            $display("unique_ordered_list test failed");
        $finish;
    end

endmodule
